[sv/virtual_keyboard_uart_fifo_unit_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the keyboard receive fifo
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef VIRTUAL_KEYBOARD_UART_FIFO_UNIT_ASSERT_SVH
`define VIRTUAL_KEYBOARD_UART_FIFO_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define VKUF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define VKUF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vkuf_pkg.sv]
// ----------------------------------------------------------------------------
// vkuf_pkg
// types and constants of the keyboard receive fifo
// ----------------------------------------------------------------------------
`default_nettype none

package vkuf_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_RSVD  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_DATA_PORT  = 3'd0,
    CFG_CMD_PORT   = 3'd1,
    CFG_CTRL_KEY   = 3'd2,
    CFG_GRAPH_KEY  = 3'd3,
    CFG_STOP_KEY   = 3'd4,
    CFG_DELETE_KEY = 3'd5,
    CFG_RSVD6      = 3'd6,
    CFG_RSVD7      = 3'd7
  } cfg_idx_t;

  localparam logic [15:0] DATA_PORT_RST  = 16'd65;
  localparam logic [15:0] CMD_PORT_RST   = 16'd67;
  localparam logic [6:0]  CTRL_KEY_RST   = 7'd116;
  localparam logic [6:0]  GRAPH_KEY_RST  = 7'd115;
  localparam logic [6:0]  STOP_KEY_RST   = 7'd96;
  localparam logic [6:0]  DELETE_KEY_RST = 7'd57;

  localparam logic [7:0] STAT_TXRDY   = 8'h01;
  localparam logic [7:0] STAT_RXRDY   = 8'h02;
  localparam logic [7:0] STAT_TXEMPTY = 8'h04;
  localparam logic [7:0] DATA_EMPTY   = 8'h00;

endpackage

`default_nettype wire

[sv/vkuf_ram.sv]
// ----------------------------------------------------------------------------
// vkuf_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module vkuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/virtual_keyboard_uart_fifo_unit.sv]
// ----------------------------------------------------------------------------
// virtual_keyboard_uart_fifo_unit
// keyboard receiver behind 8251a-style data and status registers
// ----------------------------------------------------------------------------
// Takes one request per cycle (scancode push, port read, port write) unless the
// output stalls, and returns one result per request in the cycle after the
// transfer in. Pushes track Ctrl and Graph, flag the escape hotkeys Ctrl+Stop
// and Ctrl+Graph+Del instead of queueing them, and otherwise store the code in
// a ring fifo of QUEUE_DEPTH entries that keeps one slot free; a push into a
// full fifo is dropped and counted. A data-port read pops one byte, if any,
// through the ram's registered read port, so the popped byte appears with the
// result; other reads return status. The fifo ram is not cleared at reset and
// needs no clearing pass. Configuration writes are taken at any cycle
// (cfg_ready is always high) and must only be issued while the block is idle.
`default_nettype none

module virtual_keyboard_uart_fifo_unit
  import vkuf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // port_addr[15:0], scan_byte[23:16], write_data[31:24]
  input  wire logic [31:0]  s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // read_data[7:0], hotkey_escape[8], push_dropped[9], port_matched[10],
  // rx_pending[11], pushed_total[43:12], read_total[75:44],
  // dropped_total[107:76], zero[111:108]
  output logic      [111:0] m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
    logic [AW-1:0] res;
    if (idx == LAST_IDX) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  // configuration
  logic [15:0] data_port;
  logic [15:0] cmd_port;
  logic [6:0]  ctrl_key;
  logic [6:0]  graph_key;
  logic [6:0]  stop_key;
  logic [6:0]  delete_key;

  // fifo and key state
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic          ctrl_held, ctrl_held_next;
  logic          graph_held, graph_held_next;
  logic [31:0]   push_count, push_count_next;
  logic [31:0]   read_count, read_count_next;
  logic [31:0]   drop_count, drop_count_next;

  // result register
  logic        out_valid;
  logic        pop_q;
  logic [7:0]  rdata_q;
  logic        hotkey_q;
  logic        dropped_q;
  logic        matched_q;
  logic        pending_q;

  // combinational step
  logic        accept;
  req_t        req;
  logic [15:0] port;
  logic [7:0]  scan;
  logic [6:0]  key;
  logic        make;
  logic        nonempty;
  logic        hotkey;
  logic        dropped;
  logic        matched;
  logic        do_push;
  logic        do_pop;
  logic [7:0]  rdata;
  logic [7:0]  ram_rdata;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign req  = req_t'(s_axis_tuser);
  assign port = s_axis_tdata[15:0];
  assign scan = s_axis_tdata[23:16];
  assign key  = scan[6:0];
  assign make = !scan[7];
  assign nonempty = (head != tail);
  assign matched  = (port == data_port) || (port == cmd_port);

  always_comb begin
    ctrl_held_next  = ctrl_held;
    graph_held_next = graph_held;
    head_next       = head;
    tail_next       = tail;
    push_count_next = push_count;
    read_count_next = read_count;
    drop_count_next = drop_count;
    hotkey          = 1'b0;
    dropped         = 1'b0;
    do_push         = 1'b0;
    do_pop          = 1'b0;
    rdata           = DATA_EMPTY;
    unique case (req)
      REQ_PUSH: begin
        // modifier state is updated before the hotkey test
        if (key == ctrl_key) begin
          ctrl_held_next = make;
        end else if (key == graph_key) begin
          graph_held_next = make;
        end
        if (make && ctrl_held_next &&
            ((key == stop_key) || ((key == delete_key) && graph_held_next))) begin
          hotkey = 1'b1;
        end else if (advance(tail) == head) begin
          dropped         = 1'b1;
          drop_count_next = drop_count + 32'd1;
        end else begin
          do_push         = 1'b1;
          tail_next       = advance(tail);
          push_count_next = push_count + 32'd1;
        end
      end
      REQ_READ: begin
        if (port == data_port) begin
          if (nonempty) begin
            do_pop          = 1'b1;
            head_next       = advance(head);
            read_count_next = read_count + 32'd1;
          end
        end else begin
          rdata = STAT_TXRDY | STAT_TXEMPTY | (nonempty ? STAT_RXRDY : DATA_EMPTY);
        end
      end
      REQ_WRITE, REQ_RSVD: begin
        // writes are ignored
      end
      default: begin
      end
    endcase
  end

  vkuf_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (accept && do_push),
    .wr_addr (tail),
    .wr_data (scan),
    .rd_en   (accept && do_pop),
    .rd_addr (head),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      data_port  <= DATA_PORT_RST;
      cmd_port   <= CMD_PORT_RST;
      ctrl_key   <= CTRL_KEY_RST;
      graph_key  <= GRAPH_KEY_RST;
      stop_key   <= STOP_KEY_RST;
      delete_key <= DELETE_KEY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DATA_PORT:  data_port  <= cfg_data;
        CFG_CMD_PORT:   cmd_port   <= cfg_data;
        CFG_CTRL_KEY:   ctrl_key   <= cfg_data[6:0];
        CFG_GRAPH_KEY:  graph_key  <= cfg_data[6:0];
        CFG_STOP_KEY:   stop_key   <= cfg_data[6:0];
        CFG_DELETE_KEY: delete_key <= cfg_data[6:0];
        CFG_RSVD6, CFG_RSVD7: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      ctrl_held  <= 1'b0;
      graph_held <= 1'b0;
      push_count <= '0;
      read_count <= '0;
      drop_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        head       <= head_next;
        tail       <= tail_next;
        ctrl_held  <= ctrl_held_next;
        graph_held <= graph_held_next;
        push_count <= push_count_next;
        read_count <= read_count_next;
        drop_count <= drop_count_next;
        out_valid  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_q     <= do_pop;
      rdata_q   <= rdata;
      hotkey_q  <= hotkey;
      dropped_q <= dropped;
      matched_q <= matched;
      pending_q <= (head_next != tail_next);
    end
  end

  // popped byte comes straight from the ram read register
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, drop_count, read_count, push_count, pending_q,
                          matched_q, dropped_q, hotkey_q,
                          (pop_q ? ram_rdata : rdata_q)};

  `include "virtual_keyboard_uart_fifo_unit_assert.svh"

  `VKUF_ASSERT_SAME(a_pending_tracks_ptrs, out_valid, pending_q == (head != tail), "rx_pending disagrees with fifo pointers")
  `VKUF_ASSERT_SAME(a_hotkey_needs_ctrl, out_valid && hotkey_q, ctrl_held && !dropped_q, "hotkey flagged without ctrl held or with drop")
  `VKUF_ASSERT_NEXT(a_push_nonempty, accept && do_push, head != tail, "fifo empty right after a queued push")
  `VKUF_ASSERT_NEXT(a_pop_counts, accept && do_pop, read_count == $past(read_count) + 32'd1, "pop not counted")
  `VKUF_ASSERT_NEXT(a_drop_keeps_tail, accept && dropped, tail == $past(tail), "tail moved on a dropped push")

endmodule

`default_nettype wire
